// File: rtl/b64e_pkg.sv
// shared types, constants and the character lookup for the base64 stream encoder
`default_nettype none

package b64e_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned GROUP_W  = 24;
  localparam int unsigned SEXTET_W = 6;

  localparam logic [BYTE_W-1:0] PAD_CHAR = 8'h3D;

  localparam logic [1:0] CNT_ZERO = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;

  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_THIRD  = 2'd2;
  localparam logic [1:0] POS_FOURTH = 2'd3;

  // one gathered group of one to three bytes, left aligned
  typedef struct packed {
    logic [GROUP_W-1:0] bits;
    logic [1:0]         have;
    logic               last;
  } group_t;

  function automatic logic [BYTE_W-1:0] b64_char(input logic [SEXTET_W-1:0] v);
    logic [BYTE_W-1:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v - 6'd26};
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v - 6'd52};
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/b64e_front.sv
// front part: gathers raw bytes into groups and hands finished groups on
`default_nettype none

module b64e_front import b64e_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] in_byte,
  input  wire logic              in_final,
  output logic                   push_valid,
  output group_t                 push_item,
  input  wire logic              push_ready
);

  logic [15:0] pending;
  logic [1:0]  cnt;
  logic        take;
  logic        closes;

  assign in_ready = push_ready;
  assign take     = in_valid && in_ready;
  assign closes   = (cnt == CNT_TWO) || in_final;

  always_comb begin
    push_valid     = take && closes;
    push_item.last = in_final;
    case (cnt)
      CNT_ZERO: begin
        push_item.bits = {in_byte, 16'h0000};
        push_item.have = 2'd1;
      end
      CNT_ONE: begin
        push_item.bits = {pending[15:8], in_byte, 8'h00};
        push_item.have = 2'd2;
      end
      default: begin
        push_item.bits = {pending, in_byte};
        push_item.have = 2'd3;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= CNT_ZERO;
    end else if (take) begin
      if (closes) begin
        cnt <= CNT_ZERO;
      end else begin
        cnt <= cnt + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && !closes) begin
      if (cnt == CNT_ZERO) begin
        pending <= {in_byte, 8'h00};
      end else begin
        pending <= {pending[15:8], in_byte};
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/b64e_queue.sv
// short queue of gathered groups between the front and back parts
`default_nettype none

module b64e_queue import b64e_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  input  group_t    push_item,
  output logic      push_ready,
  output logic      pop_valid,
  output group_t    pop_item,
  input  wire logic pop_ready
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  group_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

// File: rtl/b64e_back.sv
// back part: turns one group into four characters, one per cycle while the output is not stalled
`default_nettype none

module b64e_back import b64e_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               pop_valid,
  input  group_t                  pop_item,
  output logic                    pop_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [BYTE_W-1:0]       out_char,
  output logic                    out_last
);

  group_t                cur;
  logic                  busy;
  logic [1:0]            idx;
  logic                  adv;
  logic                  at_end;
  logic [SEXTET_W-1:0]   sextet;
  logic [BYTE_W-1:0]     ch;

  assign adv       = !out_valid || out_ready;
  assign at_end    = adv && (idx == POS_FOURTH);
  assign pop_ready = !busy || at_end;

  always_comb begin
    case (idx)
      POS_FIRST:  sextet = cur.bits[23:18];
      POS_SECOND: sextet = cur.bits[17:12];
      POS_THIRD:  sextet = cur.bits[11:6];
      default:    sextet = cur.bits[5:0];
    endcase
    // positions past the bytes present become padding
    ch = (idx > cur.have) ? PAD_CHAR : b64_char(sextet);
  end

  // idx wraps back to the first position at the end of a group, so it is
  // already there whenever a new group is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= POS_FIRST;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= busy;
        if (busy) begin
          idx <= idx + 2'd1;
        end
      end
      if (pop_valid && pop_ready) begin
        busy <= 1'b1;
      end else if (busy && at_end) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      cur <= pop_item;
    end
    if (adv && busy) begin
      out_char <= ch;
      out_last <= cur.last && (idx == POS_FOURTH);
    end
  end

endmodule

`default_nettype wire

// File: rtl/base64_stream_encoder_unit.sv
// path: a group passes the queue slot, the group register and the character output register
// throughput: one byte request per cycle while the queue has room, one character per cycle
// out while the output is not stalled; a group of three bytes gives four characters
// groups of one or two bytes also give four characters (padding characters)
// reset: synchronous, clears the pending count, the queue pointers and the output valid
`default_nettype none

module base64_stream_encoder_unit import b64e_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,   // final_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [7:0] out_char
  output logic             m_tlast    // out_last
);

  logic   push_valid;
  logic   push_ready;
  group_t push_item;
  logic   pop_valid;
  logic   pop_ready;
  group_t pop_item;

  b64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_byte    (s_tdata),
    .in_final   (s_tlast),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  b64e_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop_ready (pop_ready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_char  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

`default_nettype wire

// File: rtl/b64e_checker.sv
// port-level checks for the base64 stream encoder, bound to the top level
`default_nettype none

module b64e_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tready,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast
);

  // a stalled character holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output request changed while stalled");

  // every character is from the alphabet or is padding
  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata >= 8'h41 && m_tdata <= 8'h5A) ||
                 (m_tdata >= 8'h61 && m_tdata <= 8'h7A) ||
                 (m_tdata >= 8'h30 && m_tdata <= 8'h39) ||
                 m_tdata == 8'h2B || m_tdata == 8'h2F || m_tdata == 8'h3D)
    else $error("output character outside the base64 set");

  // nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) && !rst |-> !m_tvalid)
    else $error("output valid right after reset");

  // the input side is open again once reset is gone
  a_ready_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> s_tready)
    else $error("input not ready after reset");

endmodule

bind base64_stream_encoder_unit b64e_checker u_b64e_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

// File: tb/sv/tb_base64_stream_encoder_unit.sv
// self-checking testbench for the base64 stream encoder: directed and random messages
`default_nettype none

module tb_base64_stream_encoder_unit import b64e_pkg::*; ();

  localparam string B64_SYMBOLS =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam int unsigned RANDOM_BYTES = 470;
  localparam int unsigned DRAIN_LIMIT  = 20000;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } b64_char_t;

  // tracks the bytes held by the encoder and the characters they will produce
  class b64_char_tracker;
    logic [15:0] held_bytes;
    logic [1:0]  held_count;
    b64_char_t   expected_chars[$];
    int unsigned chars_checked;
    int unsigned mismatches;

    function new();
      held_bytes    = '0;
      held_count    = CNT_ZERO;
      chars_checked = 0;
      mismatches    = 0;
    endfunction

    function logic [7:0] symbol(input logic [5:0] v);
      return B64_SYMBOLS[v];
    endfunction

    function void note_char(input b64_char_t c);
      expected_chars = {expected_chars, c};
    endfunction

    function void add_byte(input logic [7:0] b, input logic fin);
      logic [23:0] grp;
      b64_char_t   c;
      if (held_count != CNT_TWO && !fin) begin
        if (held_count == CNT_ZERO) begin
          held_bytes = {b, 8'h00};
        end else begin
          held_bytes[7:0] = b;
        end
        held_count = held_count + 2'd1;
      end else begin
        case (held_count)
          CNT_ZERO: grp = {b, 16'h0000};
          CNT_ONE:  grp = {held_bytes[15:8], b, 8'h00};
          default:  grp = {held_bytes, b};
        endcase
        c.last = 1'b0;
        c.ch = symbol(grp[23:18]);
        note_char(c);
        c.ch = symbol(grp[17:12]);
        note_char(c);
        c.ch = (held_count != CNT_ZERO) ? symbol(grp[11:6]) : PAD_CHAR;
        note_char(c);
        c.ch = (held_count == CNT_TWO) ? symbol(grp[5:0]) : PAD_CHAR;
        c.last = fin;
        note_char(c);
        held_bytes = '0;
        held_count = CNT_ZERO;
      end
    endfunction

    function void check_char(input logic [7:0] ch, input logic last);
      b64_char_t e;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual ch=%h last=%b",
                 $time, ch, last);
        mismatches++;
      end else begin
        e = expected_chars.pop_front();
        chars_checked++;
        if (ch !== e.ch) begin
          $display("%0t: out_char mismatch: expected %h, actual %h", $time, e.ch, ch);
          mismatches++;
        end
        if (last !== e.last) begin
          $display("%0t: out_last mismatch: expected %b, actual %b", $time, e.last, last);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;
  logic       s_tlast  = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;

  b64_char_tracker tracker;
  logic            no_gaps = 1'b0;
  int unsigned     messages_sent;
  int unsigned     random_sent;

  always #10 clk = ~clk;

  base64_stream_encoder_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= no_gaps || ($urandom_range(99) >= 34);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      tracker.check_char(m_tdata, m_tlast);
    end
  end

  // valid stays high between back-to-back requests, lowered only for a gap
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (!no_gaps && $urandom_range(99) < 34) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 34) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.add_byte(b, fin);
    if (fin) messages_sent++;
  endtask

  task automatic wait_all_chars();
    int unsigned n;
    n = 0;
    s_tvalid <= 1'b0;
    while (tracker.expected_chars.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
  endtask

  task automatic send_random_message();
    int unsigned len;
    logic [7:0]  b;
    len = ($urandom_range(7) == 0) ? $urandom_range(30, 8) : $urandom_range(7, 1);
    for (int unsigned i = 0; i < len; i++) begin
      case ($urandom_range(15))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        default: b = 8'($urandom_range(255));
      endcase
      no_gaps = (random_sent >= 150 && random_sent < 260);
      send_byte(b, i == len - 1);
      random_sent++;
    end
  endtask

  initial begin
    logic [7:0] directed_bytes[$];
    logic       directed_fin[$];
    bit         paused;
    tracker       = new();
    messages_sent = 0;
    random_sent   = 0;
    paused        = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // lone bytes at both extremes, two-byte and three-byte finals, a group then
    // a padded tail, sextets of value 62 ('+') and all-ones bytes ('/')
    directed_bytes = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'hFF, 8'hFF, 8'hFF,
                       8'h00, 8'h00, 8'h00, 8'h01, 8'hFB, 8'hEF, 8'hBE, 8'hFF, 8'h00,
                       8'h4D, 8'h61, 8'h6E, 8'h4D, 8'h61};
    directed_fin   = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1,
                       1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                       1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
    foreach (directed_bytes[i]) send_byte(directed_bytes[i], directed_fin[i]);
    wait_all_chars();

    while (random_sent < RANDOM_BYTES) begin
      send_random_message();
      if (!paused && random_sent >= 320) begin
        wait_all_chars();
        paused = 1'b1;
      end
    end
    s_tvalid <= 1'b0;
    wait_all_chars();
    repeat (20) @(posedge clk);

    if (tracker.expected_chars.size() != 0) begin
      $display("%0t: %0d expected characters never arrived", $time,
               tracker.expected_chars.size());
      tracker.mismatches++;
    end
    $display("encoded %0d messages (%0d random bytes), %0d characters checked",
             messages_sent, random_sent, tracker.chars_checked);
    $display("covered padded and unpadded final groups, extreme bytes and random stalls");
    if (tracker.mismatches == 0) begin
      $display("base64_stream_encoder_unit regression: pass");
    end else begin
      $display("base64_stream_encoder_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("base64_stream_encoder_unit regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
